@@ design/rfkl_pkg.sv @@
package rfkl_pkg;

   localparam int KEY_SLOTS_DEF = 16;

   localparam int OP_W      = 3;
   localparam int CODE_W    = 32;
   localparam int FUNC_W    = 3;
   localparam int IDX_W     = 4;
   localparam int CMD_W     = 3;
   localparam int PCT_W     = 7;
   localparam int PHASE_W   = 3;
   localparam int KCNT_W    = 5;
   localparam int DEB_W     = 16;
   localparam int TMO_W     = 20;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;
   localparam int TIME_W    = 32;

   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_CODE  = 3'd1;
   localparam logic [OP_W-1:0] OP_LEARN = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEDEST   = 2'd2;

   localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd500;
   localparam logic [TMO_W-1:0] TIMEOUT_RST  = 20'd30000;
   localparam logic [PCT_W-1:0] PEDEST_RST   = 7'd50;
   localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;

   localparam logic [FUNC_W-1:0] FN_PEDEST = 3'd3;
   localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd4;

   localparam logic [PHASE_W-1:0] PH_OFF    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_OPEN   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PEDEST = 3'd4;

   typedef logic [1:0] tab_op_type;
   localparam tab_op_type TAB_APPEND = 2'd0;
   localparam tab_op_type TAB_MATCH  = 2'd1;
   localparam tab_op_type TAB_DELETE = 2'd2;

   typedef struct packed {
      logic              start;
      tab_op_type        op;
      logic [CODE_W-1:0] code;
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  idx;
   } tab_req_type;

   typedef struct packed {
      logic              done;
      logic              hit;
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              changed;
   } tab_rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [FUNC_W-1:0] func;
   } key_entry_type;

endpackage

@@ design/rfkl_ram.sv @@
module rfkl_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rfkl_keytab.sv @@
module rfkl_keytab
   import rfkl_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tab_req_type                    tab_req,
   output tab_rsp_type                    tab_rsp,
   output logic [$clog2(KEY_SLOTS+1)-1:0] total
);

   localparam int AW    = $clog2(KEY_SLOTS);
   localparam int CW    = $clog2(KEY_SLOTS + 1);
   localparam int ENT_W = CODE_W + FUNC_W;

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_MATCH = 2'd1;
   localparam logic [1:0] T_DEL   = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   key_entry_type wr_ent;
   key_entry_type rd_ent;
   logic [ENT_W-1:0] rd_bits;
   logic          more;
   logic          is_full;

   rfkl_ram #(
      .WIDTH(ENT_W),
      .DEPTH(KEY_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(ENT_W'(wr_ent)),
      .rd_addr(ptr_ff[AW-1:0]),
      .rd_data(rd_bits)
   );

   assign rd_ent  = key_entry_type'(rd_bits);
   assign more    = ptr_ff < total_ff;
   assign is_full = total_ff >= CW'(KEY_SLOTS);

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = total_ff[AW-1:0];
      wr_ent   = '{code: tab_req.code, func: tab_req.func};
      tab_rsp  = '0;
      unique case (state_ff)
         T_IDLE: begin
            if (tab_req.start) begin
               unique case (tab_req.op)
                  TAB_APPEND: begin
                     tab_rsp.done = 1'b1;
                     if (is_full) begin
                        tab_rsp.full = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                  end
                  TAB_MATCH: begin
                     ptr_in   = '0;
                     state_in = T_MATCH;
                  end
                  TAB_DELETE: begin
                     if (32'(tab_req.idx) < 32'(total_ff)) begin
                        ptr_in   = CW'(32'(tab_req.idx) + 32'd1);
                        state_in = T_DEL;
                     end else begin
                        tab_rsp.done = 1'b1;
                     end
                  end
                  default: begin
                     tab_rsp.done = 1'b1;
                  end
               endcase
            end
         end
         T_MATCH: begin
            if (pend_ff && rd_ent.code == tab_req.code) begin
               tab_rsp.done = 1'b1;
               tab_rsp.hit  = rd_ent.func <= FN_TOGGLE;
               tab_rsp.func = rd_ent.func;
               state_in     = T_IDLE;
            end else if (more) begin
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               tab_rsp.done = 1'b1;
               state_in     = T_IDLE;
            end
         end
         T_DEL: begin
            // data read from ptr-1 moves down to ptr-2
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(ptr_ff - CW'(2));
               wr_ent  = rd_ent;
            end
            if (more) begin
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               tab_rsp.done    = 1'b1;
               tab_rsp.changed = 1'b1;
               total_in        = total_ff - 1'b1;
               state_in        = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         total_ff <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
   end

   assign total = total_ff;

endmodule

@@ design/rf_remote_key_learn_match.sv @@
// channel   | handshake            | payload
// req       | req_valid/req_ready  | operation, code, function_req, index
// rsp       | rsp_valid/rsp_ready  | command, status flags, learn phase, key count
// csr       | csr_write_en         | csr_index, csr_wdata (no read-back)
// one request at a time; tick, learn, add and learning receive finish without waiting on the table
// a received code outside learning scans the key table, one slot per cycle
// a delete shifts later keys down through the table memory
// a new request is taken while the previous response waits on rsp_ready
// synchronous reset empties the table and restores the register defaults
module rf_remote_key_learn_match
   import rfkl_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [CODE_W-1:0]    req_code,
   input  logic [FUNC_W-1:0]    req_function_req,
   input  logic [IDX_W-1:0]     req_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_command_valid,
   output logic [CMD_W-1:0]     rsp_command,
   output logic [PCT_W-1:0]     rsp_position_percent,
   output logic [PHASE_W-1:0]   rsp_learn_phase,
   output logic [KCNT_W-1:0]    rsp_keys_stored,
   output logic                 rsp_update_request,
   output logic                 rsp_table_saved,
   output logic                 rsp_learn_finished,
   output logic                 rsp_learn_timed_out,
   output logic                 rsp_table_full,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(KEY_SLOTS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;

   logic [DEB_W-1:0]   debounce_ff;
   logic [TMO_W-1:0]   timeout_ff;
   logic [PCT_W-1:0]   pedest_ff;

   logic [OP_W-1:0]    op_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [FUNC_W-1:0]  func_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [CODE_W-1:0]  last_code_ff, last_code_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic [PHASE_W-1:0] mode_ff, mode_in;
   logic [TIME_W-1:0]  start_ff, start_in;

   logic               r_cmd_valid_ff, r_cmd_valid_in;
   logic [CMD_W-1:0]   r_cmd_ff, r_cmd_in;
   logic [PCT_W-1:0]   r_pos_ff, r_pos_in;
   logic               r_upd_ff, r_upd_in;
   logic               r_saved_ff, r_saved_in;
   logic               r_fin_ff, r_fin_in;
   logic               r_tmo_ff, r_tmo_in;
   logic               r_full_ff, r_full_in;

   logic               rsp_valid_ff;
   logic               rsp_cmd_valid_ff;
   logic [CMD_W-1:0]   rsp_cmd_ff;
   logic [PCT_W-1:0]   rsp_pos_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;
   logic [KCNT_W-1:0]  rsp_keys_ff;
   logic               rsp_upd_ff;
   logic               rsp_saved_ff;
   logic               rsp_fin_ff;
   logic               rsp_tmo_ff;
   logic               rsp_full_ff;

   tab_req_type        tab_req;
   tab_rsp_type        tab_rsp;
   logic [CW-1:0]      total;

   logic [TIME_W-1:0]  learn_age;
   logic [TIME_W-1:0]  accept_age;
   logic [PCT_W-1:0]   pedest_sat;
   logic               accept;
   logic               load_rsp;

   rfkl_keytab #(
      .KEY_SLOTS(KEY_SLOTS)
   ) u_keytab (
      .clock  (clock),
      .reset  (reset),
      .tab_req(tab_req),
      .tab_rsp(tab_rsp),
      .total  (total)
   );

   assign req_ready  = state_ff == S_IDLE;
   assign accept     = req_valid && req_ready;
   assign load_rsp   = state_ff == S_DONE && (!rsp_valid_ff || rsp_ready);
   assign learn_age  = now_ff - start_ff;
   assign accept_age = now_ff - last_time_ff;
   assign pedest_sat = pedest_ff > PCT_MAX ? PCT_MAX : pedest_ff;

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      last_code_in   = last_code_ff;
      last_time_in   = last_time_ff;
      mode_in        = mode_ff;
      start_in       = start_ff;
      r_cmd_valid_in = r_cmd_valid_ff;
      r_cmd_in       = r_cmd_ff;
      r_pos_in       = r_pos_ff;
      r_upd_in       = r_upd_ff;
      r_saved_in     = r_saved_ff;
      r_fin_in       = r_fin_ff;
      r_tmo_in       = r_tmo_ff;
      r_full_in      = r_full_ff;
      tab_req        = '{start: 1'b0, op: TAB_APPEND, code: code_ff, func: func_ff,
                         idx: idx_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               r_cmd_valid_in = 1'b0;
               r_cmd_in       = '0;
               r_pos_in       = '0;
               r_upd_in       = 1'b0;
               r_saved_in     = 1'b0;
               r_fin_in       = 1'b0;
               r_tmo_in       = 1'b0;
               r_full_in      = 1'b0;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_TICK: begin
                  now_in = now_ff + 1'b1;
                  // age after the increment exceeds the timeout
                  if (mode_ff != PH_OFF && learn_age >= TIME_W'(timeout_ff)
                      && learn_age != '1) begin
                     mode_in  = PH_OFF;
                     r_tmo_in = 1'b1;
                  end
               end
               OP_CODE: begin
                  if (code_ff != '0) begin
                     if (mode_ff != PH_OFF) begin
                        tab_req.start = 1'b1;
                        tab_req.func  = mode_ff - 1'b1;
                        r_upd_in      = 1'b1;
                        r_full_in     = tab_rsp.full;
                        start_in      = now_ff;
                        if (mode_ff == PH_PEDEST) begin
                           mode_in    = PH_OFF;
                           r_saved_in = 1'b1;
                           r_fin_in   = 1'b1;
                        end else begin
                           mode_in = mode_ff + 1'b1;
                        end
                     end else if (!(code_ff == last_code_ff &&
                                    accept_age < TIME_W'(debounce_ff))) begin
                        last_code_in  = code_ff;
                        last_time_in  = now_ff;
                        r_upd_in      = 1'b1;
                        tab_req.start = 1'b1;
                        tab_req.op    = TAB_MATCH;
                        state_in      = S_WAIT;
                     end
                  end
               end
               OP_LEARN: begin
                  mode_in  = PH_OPEN;
                  start_in = now_ff;
               end
               OP_ADD: begin
                  tab_req.start = 1'b1;
                  r_full_in     = tab_rsp.full;
                  r_saved_in    = !tab_rsp.full;
               end
               OP_DEL: begin
                  tab_req.start = 1'b1;
                  tab_req.op    = TAB_DELETE;
                  if (!tab_rsp.done) begin
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WAIT: begin
            tab_req.op = op_ff == OP_DEL ? TAB_DELETE : TAB_MATCH;
            if (tab_rsp.done) begin
               state_in = S_DONE;
               if (op_ff == OP_DEL) begin
                  r_saved_in = tab_rsp.changed;
               end else if (tab_rsp.hit) begin
                  r_cmd_valid_in = 1'b1;
                  r_cmd_in       = tab_rsp.func;
                  r_pos_in       = tab_rsp.func == FN_PEDEST ? pedest_sat : '0;
               end
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         debounce_ff  <= DEBOUNCE_RST;
         timeout_ff   <= TIMEOUT_RST;
         pedest_ff    <= PEDEST_RST;
         now_ff       <= '0;
         last_code_ff <= '0;
         last_time_ff <= '0;
         mode_ff      <= PH_OFF;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         last_code_ff <= last_code_in;
         last_time_ff <= last_time_in;
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DEBOUNCE: debounce_ff <= csr_wdata[DEB_W-1:0];
               CSR_TIMEOUT:  timeout_ff  <= csr_wdata[TMO_W-1:0];
               CSR_PEDEST:   pedest_ff   <= csr_wdata[PCT_W-1:0];
               default: begin
               end
            endcase
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         code_ff <= req_code;
         func_ff <= req_function_req;
         idx_ff  <= req_index;
      end
      r_cmd_valid_ff <= r_cmd_valid_in;
      r_cmd_ff       <= r_cmd_in;
      r_pos_ff       <= r_pos_in;
      r_upd_ff       <= r_upd_in;
      r_saved_ff     <= r_saved_in;
      r_fin_ff       <= r_fin_in;
      r_tmo_ff       <= r_tmo_in;
      r_full_ff      <= r_full_in;
      if (load_rsp) begin
         rsp_cmd_valid_ff <= r_cmd_valid_ff;
         rsp_cmd_ff       <= r_cmd_ff;
         rsp_pos_ff       <= r_pos_ff;
         rsp_phase_ff     <= mode_ff;
         rsp_keys_ff      <= KCNT_W'(total);
         rsp_upd_ff       <= r_upd_ff;
         rsp_saved_ff     <= r_saved_ff;
         rsp_fin_ff       <= r_fin_ff;
         rsp_tmo_ff       <= r_tmo_ff;
         rsp_full_ff      <= r_full_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_valid    = rsp_cmd_valid_ff;
   assign rsp_command          = rsp_cmd_ff;
   assign rsp_position_percent = rsp_pos_ff;
   assign rsp_learn_phase      = rsp_phase_ff;
   assign rsp_keys_stored      = rsp_keys_ff;
   assign rsp_update_request   = rsp_upd_ff;
   assign rsp_table_saved      = rsp_saved_ff;
   assign rsp_learn_finished   = rsp_fin_ff;
   assign rsp_learn_timed_out  = rsp_tmo_ff;
   assign rsp_table_full       = rsp_full_ff;

endmodule

@@ tb/rf_remote_key_learn_match_tb.sv @@
`timescale 1ns / 100ps

module rf_remote_key_learn_match_tb;
   import rfkl_pkg::*;

   localparam int KEYS        = KEY_SLOTS_DEF;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 240;
   localparam int SETTLE      = KEYS + 8;
   localparam int HOLD_CYCLES = 300;
   localparam int POOL        = 8;
   localparam int ERROR_LIMIT = 200;

   localparam logic [FUNC_W-1:0] FN_OPEN  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_CLOSE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ODD   = 3'd7;
   localparam logic [OP_W-1:0]   OP_SPARE = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [CODE_W-1:0] code;
      logic [FUNC_W-1:0] function_req;
      logic [IDX_W-1:0]  index;
   } gate_req_t;

   typedef struct packed {
      logic               command_valid;
      logic [CMD_W-1:0]   command;
      logic [PCT_W-1:0]   position_percent;
      logic [PHASE_W-1:0] learn_phase;
      logic [KCNT_W-1:0]  keys_stored;
      logic               update_request;
      logic               table_saved;
      logic               learn_finished;
      logic               learn_timed_out;
      logic               table_full;
   } gate_rsp_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation = OP_TICK;
   logic [CODE_W-1:0]    req_code = '0;
   logic [FUNC_W-1:0]    req_function_req = FN_OPEN;
   logic [IDX_W-1:0]     req_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_command_valid;
   logic [CMD_W-1:0]     rsp_command;
   logic [PCT_W-1:0]     rsp_position_percent;
   logic [PHASE_W-1:0]   rsp_learn_phase;
   logic [KCNT_W-1:0]    rsp_keys_stored;
   logic                 rsp_update_request;
   logic                 rsp_table_saved;
   logic                 rsp_learn_finished;
   logic                 rsp_learn_timed_out;
   logic                 rsp_table_full;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEBOUNCE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // shadow of the key manager state
   logic [TIME_W-1:0]  clock_ms = '0;
   logic [CODE_W-1:0]  last_code = '0;
   logic [TIME_W-1:0]  last_code_ms = '0;
   logic [PHASE_W-1:0] learn_step = PH_OFF;
   logic [TIME_W-1:0]  learn_since = '0;
   logic [CODE_W-1:0]  key_codes [KEYS];
   logic [FUNC_W-1:0]  key_funcs [KEYS];
   int                 key_count = 0;
   logic [DEB_W-1:0]   cfg_debounce = DEBOUNCE_RST;
   logic [TMO_W-1:0]   cfg_timeout = TIMEOUT_RST;
   logic [PCT_W-1:0]   cfg_pedest = PEDEST_RST;

   gate_req_t request_backlog [$];
   gate_rsp_t expected_outcomes [$];
   gate_req_t offered_req;
   logic [CODE_W-1:0] code_pool [POOL];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic pressure_go = 1'b0;
   logic hold_rsp = 1'b0;

   int requests_sent = 0;
   int responses_seen = 0;
   int mismatches = 0;
   int commands_seen = 0;
   int learns_done = 0;
   int learn_expiries = 0;
   int adds_dropped = 0;

   rf_remote_key_learn_match uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_code             (req_code),
      .req_function_req     (req_function_req),
      .req_index            (req_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_command_valid    (rsp_command_valid),
      .rsp_command          (rsp_command),
      .rsp_position_percent (rsp_position_percent),
      .rsp_learn_phase      (rsp_learn_phase),
      .rsp_keys_stored      (rsp_keys_stored),
      .rsp_update_request   (rsp_update_request),
      .rsp_table_saved      (rsp_table_saved),
      .rsp_learn_finished   (rsp_learn_finished),
      .rsp_learn_timed_out  (rsp_learn_timed_out),
      .rsp_table_full       (rsp_table_full),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic store_key(logic [CODE_W-1:0] code, logic [FUNC_W-1:0] fn);
      if (key_count >= KEYS) begin
         return 1'b0;
      end
      key_codes[key_count] = code;
      key_funcs[key_count] = fn;
      key_count++;
      return 1'b1;
   endfunction

   function automatic gate_rsp_t apply_gate_request(gate_req_t rq);
      gate_rsp_t o;
      logic [TIME_W-1:0] span;
      logic [FUNC_W-1:0] fn;
      logic searching;
      int i;
      o = '0;
      case (rq.operation)
         OP_TICK: begin
            clock_ms = clock_ms + 1;
            span = clock_ms - learn_since;
            if (learn_step != PH_OFF && span > TIME_W'(cfg_timeout)) begin
               learn_step = PH_OFF;
               o.learn_timed_out = 1'b1;
            end
         end
         OP_CODE: begin
            if (rq.code != '0) begin
               if (learn_step != PH_OFF) begin
                  o.update_request = 1'b1;
                  if (!store_key(rq.code, FUNC_W'(learn_step - PH_OPEN))) begin
                     o.table_full = 1'b1;
                  end
                  learn_since = clock_ms;
                  if (learn_step == PH_PEDEST) begin
                     learn_step = PH_OFF;
                     o.table_saved = 1'b1;
                     o.learn_finished = 1'b1;
                  end else begin
                     learn_step = learn_step + 1'b1;
                  end
               end else begin
                  span = clock_ms - last_code_ms;
                  if (!(rq.code == last_code && span < TIME_W'(cfg_debounce))) begin
                     last_code = rq.code;
                     last_code_ms = clock_ms;
                     o.update_request = 1'b1;
                     searching = 1'b1;
                     for (i = 0; i < key_count && searching; i++) begin
                        if (key_codes[i] == rq.code) begin
                           searching = 1'b0;
                           fn = key_funcs[i];
                           if (fn <= FN_TOGGLE) begin
                              o.command_valid = 1'b1;
                              o.command = fn;
                              if (fn == FN_PEDEST) begin
                                 o.position_percent = (cfg_pedest > PCT_MAX) ? PCT_MAX
                                                                             : cfg_pedest;
                              end
                           end
                        end
                     end
                  end
               end
            end
         end
         OP_LEARN: begin
            learn_step = PH_OPEN;
            learn_since = clock_ms;
         end
         OP_ADD: begin
            if (store_key(rq.code, rq.function_req)) begin
               o.table_saved = 1'b1;
            end else begin
               o.table_full = 1'b1;
            end
         end
         OP_DEL: begin
            if (int'(rq.index) < key_count) begin
               for (i = int'(rq.index); i + 1 < key_count; i++) begin
                  key_codes[i] = key_codes[i + 1];
                  key_funcs[i] = key_funcs[i + 1];
               end
               key_count--;
               o.table_saved = 1'b1;
            end
         end
         default: begin
         end
      endcase
      o.learn_phase = learn_step;
      o.keys_stored = KCNT_W'(key_count);
      return o;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= ERROR_LIMIT) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outcomes.insert(expected_outcomes.size(), apply_gate_request(offered_req));
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_req = request_backlog.pop_front();
               req_valid <= 1'b1;
               req_operation <= offered_req.operation;
               req_code <= offered_req.code;
               req_function_req <= offered_req.function_req;
               req_index <= offered_req.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // long receiver hold while requests keep coming
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      gate_rsp_t exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= ERROR_LIMIT) begin
               $error("response with no request outstanding");
            end
         end else begin
            exp_rsp = expected_outcomes.pop_front();
            check_field("command_valid", 32'(exp_rsp.command_valid),
                        32'(rsp_command_valid));
            check_field("command", 32'(exp_rsp.command), 32'(rsp_command));
            check_field("position_percent", 32'(exp_rsp.position_percent),
                        32'(rsp_position_percent));
            check_field("learn_phase", 32'(exp_rsp.learn_phase), 32'(rsp_learn_phase));
            check_field("keys_stored", 32'(exp_rsp.keys_stored), 32'(rsp_keys_stored));
            check_field("update_request", 32'(exp_rsp.update_request),
                        32'(rsp_update_request));
            check_field("table_saved", 32'(exp_rsp.table_saved), 32'(rsp_table_saved));
            check_field("learn_finished", 32'(exp_rsp.learn_finished),
                        32'(rsp_learn_finished));
            check_field("learn_timed_out", 32'(exp_rsp.learn_timed_out),
                        32'(rsp_learn_timed_out));
            check_field("table_full", 32'(exp_rsp.table_full), 32'(rsp_table_full));
            commands_seen += int'(exp_rsp.command_valid);
            learns_done += int'(exp_rsp.learn_finished);
            learn_expiries += int'(exp_rsp.learn_timed_out);
            adds_dropped += int'(exp_rsp.table_full);
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DEBOUNCE: cfg_debounce = data[DEB_W-1:0];
         CSR_TIMEOUT:  cfg_timeout = data[TMO_W-1:0];
         CSR_PEDEST:   cfg_pedest = data[PCT_W-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_req(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                            logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx);
      gate_req_t rq;
      rq.operation = op;
      rq.code = code;
      rq.function_req = fn;
      rq.index = idx;
      request_backlog.insert(request_backlog.size(), rq);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (request_backlog.size() != 0 || req_valid || expected_outcomes.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
         return code_pool[$urandom_range(0, POOL - 1)];
      end else if (sel < 95) begin
         return $urandom();
      end
      return '0;
   endfunction

   function automatic logic [OP_W-1:0] OP_OPEN_STEP();
      return OP_W'($urandom_range(int'(OP_SPARE - OP_DEL), 3));
   endfunction

   task automatic fill_random(int count, int add_wt);
      int made;
      int sel;
      int steps;
      int k;
      made = 0;
      while (made < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 14) begin
            // learning run, sometimes cut short, ticks in between
            queue_req(OP_LEARN, $urandom(), FUNC_W'($urandom()), IDX_W'($urandom()));
            made++;
            steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
            for (k = 0; k < steps; k++) begin
               while ($urandom_range(0, 2) == 0) begin
                  queue_req(OP_TICK, $urandom(), FUNC_W'($urandom()), IDX_W'($urandom()));
                  made++;
               end
               queue_req(OP_CODE, pick_code(), FUNC_W'($urandom()), IDX_W'($urandom()));
               made++;
            end
         end else if (sel < 36) begin
            queue_req(OP_TICK, $urandom(), FUNC_W'($urandom()), IDX_W'($urandom()));
            made++;
         end else if (sel < 62) begin
            queue_req(OP_CODE, pick_code(), FUNC_W'($urandom()), IDX_W'($urandom()));
            made++;
         end else if (sel < 62 + add_wt) begin
            queue_req(OP_ADD, pick_code(), FUNC_W'($urandom_range(0, 7)),
                      IDX_W'($urandom()));
            made++;
         end else if (sel < 95) begin
            queue_req(OP_DEL, $urandom(), FUNC_W'($urandom()),
                      IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 3)));
            made++;
         end else begin
            queue_req(OP_DEL + OP_OPEN_STEP(), $urandom(), FUNC_W'($urandom()),
                      IDX_W'($urandom()));
            made++;
         end
      end
   endtask

   initial begin
      int ph;
      int i;
      int send_mode [4];
      int recv_mode [4];
      send_mode = '{0, 74, 0, 21};
      recv_mode = '{0, 0, 74, 21};
      for (i = 0; i < KEYS; i++) begin
         key_codes[i] = '0;
         key_funcs[i] = FN_OPEN;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: pedestrian at fifty, long debounce, zero code
      queue_req(OP_ADD, 32'h0000_00A5, FN_PEDEST, '0);
      queue_req(OP_CODE, 32'h0000_00A5, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_00A5, FN_OPEN, '0);
      queue_req(OP_ADD, 32'h0, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0, FN_OPEN, '0);
      wait_drained();

      write_csr(CSR_DEBOUNCE, 20'd2);
      write_csr(CSR_TIMEOUT, 20'd3);
      write_csr(CSR_PEDEST, 20'd127);
      @(negedge clock);
      queue_req(OP_ADD, 32'hFFFF_FFFF, FN_ODD, 4'hF);
      queue_req(OP_ADD, 32'h0000_005A, FN_TOGGLE, '0);
      queue_req(OP_CODE, 32'hFFFF_FFFF, FN_ODD, 4'hF);
      queue_req(OP_CODE, 32'h0000_00A5, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_005A, FN_OPEN, '0);
      queue_req(OP_DEL, '0, FN_OPEN, 4'hF);
      queue_req(OP_DEL, '0, FN_OPEN, 4'h0);
      queue_req(OP_LEARN, '0, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_0011, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_0022, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_0033, FN_OPEN, '0);
      queue_req(OP_CODE, 32'h0000_0044, FN_OPEN, '0);
      queue_req(OP_LEARN, '0, FN_OPEN, '0);
      for (i = 0; i < 4; i++) begin
         queue_req(OP_TICK, '0, FN_OPEN, '0);
      end
      queue_req(OP_SPARE, 32'hFFFF_FFFF, FN_ODD, 4'hF);
      queue_req(OP_CODE, 32'h0000_0022, FN_CLOSE, '0);
      wait_drained();

      for (ph = 0; ph < PHASES; ph++) begin
         for (i = 0; i < POOL; i++) begin
            code_pool[i] = $urandom();
         end
         write_csr(CSR_DEBOUNCE, (ph == 0) ? 20'd0 : (ph == 1) ? 20'hFFFF
                                                  : CSR_W'($urandom_range(0, 24)));
         write_csr(CSR_TIMEOUT, (ph == 0) ? 20'd0 : (ph == 1) ? 20'hFFFFF
                                                 : CSR_W'($urandom_range(0, 6)));
         write_csr(CSR_PEDEST, (ph == 0) ? 20'd0 : (ph == 1) ? 20'd100
                                                : CSR_W'($urandom_range(0, 127)));
         @(negedge clock);
         send_idle_pct = send_mode[ph % 4];
         recv_stall_pct = recv_mode[ph % 4];
         fill_random(PHASE_ITEMS, (ph % 2 == 0) ? 20 : 10);
         if (ph == 0) begin
            pressure_go = 1'b1;
         end
         wait_drained();
      end

      $display("covered %0d requests, %0d responses: %0d gate commands, %0d learn completions",
               requests_sent, responses_seen, commands_seen, learns_done);
      $display("  %0d learn expiries, %0d adds refused on a full table",
               learn_expiries, adds_dropped);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
design/rfkl_pkg.sv
design/rfkl_ram.sv
design/rfkl_keytab.sv
design/rf_remote_key_learn_match.sv
tb/rf_remote_key_learn_match_tb.sv
